[rtl/core/bcd2ep_pkg.sv]
// ----------------------------------------------------------------------------
// bcd2ep_pkg
// Shared widths, constants and month table for the BCD calendar to epoch
// seconds converter and its checker.
// ----------------------------------------------------------------------------
package bcd2ep_pkg;

    // Field widths of one input word
    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 5;
    localparam int DAY_W    = 6;
    localparam int HOUR_W   = 6;
    localparam int MINUTE_W = 7;
    localparam int SECOND_W = 7;

    // Result width, signed seconds
    localparam int EPOCH_W  = 40;

    // Calendar constants
    localparam int SECS_PER_DAY  = 3600 * 24;
    localparam int DAYS_PER_YEAR = 365;
    localparam int YEAR_BASE     = 1900;
    localparam int EPOCH_OFFSET  = 70;
    localparam int LEAP4_OFFSET  = 69;
    localparam int LEAP100_OFFSET = 1;
    localparam int LEAP400_OFFSET = 299;

    // Reciprocals for divide by 100 and by 400, exact for magnitudes below 43690
    localparam int RECIP_DIV = 5243;
    localparam int SHIFT_DIV100 = 19;
    localparam int SHIFT_DIV400 = 21;

    // Output range bounds
    localparam longint EPOCH_MIN = -64'sd70000000000;
    localparam longint EPOCH_MAX = 64'sd500000000000;

    typedef logic [8:0] t_yday;
    typedef logic [3:0] t_midx;

    // Days elapsed before the first of the month, normal and leap years
    function automatic t_yday days_before_month(input t_midx idx, input logic leap);
        t_yday d;
        unique case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = leap ? 9'd60  : 9'd59;
            4'd3:    d = leap ? 9'd91  : 9'd90;
            4'd4:    d = leap ? 9'd121 : 9'd120;
            4'd5:    d = leap ? 9'd152 : 9'd151;
            4'd6:    d = leap ? 9'd182 : 9'd181;
            4'd7:    d = leap ? 9'd213 : 9'd212;
            4'd8:    d = leap ? 9'd244 : 9'd243;
            4'd9:    d = leap ? 9'd274 : 9'd273;
            4'd10:   d = leap ? 9'd305 : 9'd304;
            4'd11:   d = leap ? 9'd335 : 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[rtl/core/bcd_calendar_to_epoch_seconds.sv]
// ----------------------------------------------------------------------------
// bcd_calendar_to_epoch_seconds
// Converts one packed BCD date and time word into signed seconds since
// 1970-01-01 00:00:00, through a five-register pipeline.
// ----------------------------------------------------------------------------
// Stages: five registers; a word accepted into stage A passes stages B, C and D
//   and shows as a valid result word in register E, from where it can be taken.
// Throughput: one word per cycle; the pipeline advances as a whole and holds
//   only while the output word is valid and stalled.
// Reset: synchronous, active low; clears every stage valid, payload registers
//   keep their contents.
module bcd_calendar_to_epoch_seconds (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [bcd2ep_pkg::YEAR_W-1:0]        i_year_bcd,
    input  logic [bcd2ep_pkg::MONTH_W-1:0]       i_month_bcd,
    input  logic [bcd2ep_pkg::DAY_W-1:0]         i_day_bcd,
    input  logic [bcd2ep_pkg::HOUR_W-1:0]        i_hour_bcd,
    input  logic [bcd2ep_pkg::MINUTE_W-1:0]      i_minute_bcd,
    input  logic [bcd2ep_pkg::SECOND_W-1:0]      i_second_bcd,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [bcd2ep_pkg::EPOCH_W-1:0] o_epoch_seconds
);

    // Pipeline advance: hold everything while the result word is stalled
    logic r_e_vld;
    logic w_adv;
    assign w_adv   = !(r_e_vld && i_stall);
    assign o_stall = !w_adv;

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic                                 r_a_vld;
    logic [bcd2ep_pkg::YEAR_W-1:0]        r_a_year;
    logic [bcd2ep_pkg::MONTH_W-1:0]       r_a_month;
    logic [bcd2ep_pkg::DAY_W-1:0]         r_a_day;
    logic [bcd2ep_pkg::HOUR_W-1:0]        r_a_hour;
    logic [bcd2ep_pkg::MINUTE_W-1:0]      r_a_minute;
    logic [bcd2ep_pkg::SECOND_W-1:0]      r_a_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_year   <= i_year_bcd;
            r_a_month  <= i_month_bcd;
            r_a_day    <= i_day_bcd;
            r_a_hour   <= i_hour_bcd;
            r_a_minute <= i_minute_bcd;
            r_a_second <= i_second_bcd;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: weight digits, leap flag, month offset, time of day
    // ------------------------------------------------------------------
    logic [14:0]              w_year;
    logic [7:0]               w_year_lo;
    logic [7:0]               w_year_hi;
    logic                     w_cent;
    logic                     w_leap;
    logic [4:0]               w_mon;
    bcd2ep_pkg::t_midx        w_midx;
    logic [5:0]               w_day;
    logic [5:0]               w_hr;
    logic [6:0]               w_mn;
    logic [6:0]               w_sc;
    logic [17:0]              w_hms;

    always_comb begin
        // Two low digits and the century count, nibbles above 9 as they are
        w_year_lo = 8'(r_a_year[7:4]) * 8'd10 + 8'(r_a_year[3:0]);
        w_year    = 15'(r_a_year[15:12]) * 15'd1000 + 15'(r_a_year[11:8]) * 15'd100
                  + 15'(w_year_lo);
        w_cent    = (w_year_lo == 8'd0) || (w_year_lo == 8'd100);
        w_year_hi = 8'(r_a_year[15:12]) * 8'd10 + 8'(r_a_year[11:8])
                  + 8'(w_year_lo >= 8'd100);
        w_leap    = ((w_year[1:0] == 2'd0) && !w_cent)
                  || (w_cent && (w_year_hi[1:0] == 2'd0));

        // Clamp month to 1..12
        w_mon = 5'(r_a_month[4] ? 5'd10 : 5'd0) + 5'(r_a_month[3:0]);
        priority if (w_mon == 5'd0) begin
            w_midx = 4'd0;
        end else if (w_mon > 5'd12) begin
            w_midx = 4'd11;
        end else begin
            w_midx = 4'(w_mon - 5'd1);
        end

        w_day = 6'(r_a_day[5:4]) * 6'd10 + 6'(r_a_day[3:0]);
        w_hr  = 6'(r_a_hour[5:4]) * 6'd10 + 6'(r_a_hour[3:0]);
        w_mn  = 7'(r_a_minute[6:4]) * 7'd10 + 7'(r_a_minute[3:0]);
        w_sc  = 7'(r_a_second[6:4]) * 7'd10 + 7'(r_a_second[3:0]);
        w_hms = (18'(w_hr) * 18'd60 + 18'(w_mn)) * 18'd60 + 18'(w_sc);
    end

    logic                     r_b_vld;
    logic [14:0]              r_b_year;
    bcd2ep_pkg::t_yday        r_b_mdays;
    logic [5:0]               r_b_day;
    logic [17:0]              r_b_hms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_year  <= w_year;
            r_b_mdays <= bcd2ep_pkg::days_before_month(w_midx, w_leap);
            r_b_day   <= w_day;
            r_b_hms   <= w_hms;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: year terms, divisions truncate toward zero
    // ------------------------------------------------------------------
    logic signed [15:0] w_ty;
    logic signed [15:0] w_a365;
    logic signed [15:0] w_a4;
    logic signed [15:0] w_a100;
    logic signed [15:0] w_a400;
    logic [13:0]        w_m4;
    logic [13:0]        w_m100;
    logic [13:0]        w_m400;
    logic [26:0]        w_p100;
    logic [26:0]        w_p400;
    logic signed [12:0] w_q4u;
    logic signed [8:0]  w_q100u;
    logic signed [6:0]  w_q400u;
    logic signed [23:0] w_y365;

    always_comb begin
        w_ty   = $signed({1'b0, r_b_year}) - 16'(bcd2ep_pkg::YEAR_BASE);
        w_a365 = w_ty - 16'(bcd2ep_pkg::EPOCH_OFFSET);
        w_a4   = w_ty - 16'(bcd2ep_pkg::LEAP4_OFFSET);
        w_a100 = w_ty - 16'(bcd2ep_pkg::LEAP100_OFFSET);
        w_a400 = w_ty + 16'(bcd2ep_pkg::LEAP400_OFFSET);

        // Magnitudes, then unsigned quotients
        w_m4   = w_a4[15]   ? 14'(-w_a4)   : 14'(w_a4);
        w_m100 = w_a100[15] ? 14'(-w_a100) : 14'(w_a100);
        w_m400 = w_a400[15] ? 14'(-w_a400) : 14'(w_a400);
        w_p100 = 27'(w_m100) * 27'(bcd2ep_pkg::RECIP_DIV);
        w_p400 = 27'(w_m400) * 27'(bcd2ep_pkg::RECIP_DIV);

        w_q4u   = $signed({1'b0, w_m4[13:2]});
        w_q100u = $signed({1'b0, 8'(w_p100 >> bcd2ep_pkg::SHIFT_DIV100)});
        w_q400u = $signed({1'b0, 6'(w_p400 >> bcd2ep_pkg::SHIFT_DIV400)});

        w_y365 = 24'(w_a365) * 24'(bcd2ep_pkg::DAYS_PER_YEAR);
    end

    logic                     r_c_vld;
    logic signed [23:0]       r_c_y365;
    logic signed [12:0]       r_c_q4;
    logic signed [8:0]        r_c_q100;
    logic signed [6:0]        r_c_q400;
    bcd2ep_pkg::t_yday        r_c_mdays;
    logic [5:0]               r_c_day;
    logic [17:0]              r_c_hms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_c_vld <= r_b_vld;
        end
    end

    // Restore the sign of each quotient
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_y365  <= w_y365;
            r_c_q4    <= w_a4[15]   ? -w_q4u   : w_q4u;
            r_c_q100  <= w_a100[15] ? -w_q100u : w_q100u;
            r_c_q400  <= w_a400[15] ? -w_q400u : w_q400u;
            r_c_mdays <= r_b_mdays;
            r_c_day   <= r_b_day;
            r_c_hms   <= r_b_hms;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: total days since the epoch
    // ------------------------------------------------------------------
    logic signed [23:0] w_days;

    assign w_days = r_c_y365 + 24'(r_c_q4) - 24'(r_c_q100) + 24'(r_c_q400)
                  + 24'($signed({1'b0, r_c_mdays})) + 24'($signed({1'b0, r_c_day}))
                  - 24'sd1;

    logic                     r_d_vld;
    logic signed [23:0]       r_d_days;
    logic [17:0]              r_d_hms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_adv) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_days <= w_days;
            r_d_hms  <= r_c_hms;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: scale days to seconds, add time of day, result register
    // ------------------------------------------------------------------
    logic signed [41:0] w_secs;

    assign w_secs = 42'(r_d_days) * 42'(bcd2ep_pkg::SECS_PER_DAY)
                  + 42'($signed({1'b0, r_d_hms}));

    logic signed [bcd2ep_pkg::EPOCH_W-1:0] r_e_secs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_secs <= w_secs[bcd2ep_pkg::EPOCH_W-1:0];
        end
    end

    assign o_valid         = r_e_vld;
    assign o_epoch_seconds = r_e_secs;

endmodule

[rtl/core/bcd2ep_checker.sv]
// ----------------------------------------------------------------------------
// bcd2ep_checker
// Port-level checks for the BCD calendar to epoch seconds converter, bound
// to the top level.
// ----------------------------------------------------------------------------
module bcd2ep_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [bcd2ep_pkg::EPOCH_W-1:0] o_epoch_seconds
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_epoch_seconds))
        else $error("stalled result word changed");

    // Stall the input only when the result word is blocked
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall without blocked result word");

    // Drop all words on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    // Keep results in the calendar range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (64'(o_epoch_seconds) >= bcd2ep_pkg::EPOCH_MIN)
                 && (64'(o_epoch_seconds) <= bcd2ep_pkg::EPOCH_MAX))
        else $error("result word out of range");

endmodule

bind bcd_calendar_to_epoch_seconds bcd2ep_checker u_bcd2ep_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_epoch_seconds (o_epoch_seconds)
);
